>>> hdl/gif_tag_packet_unpacker_unit_assert.svh
// assertion macros shared by the checker
`ifndef GIF_TAG_PACKET_UNPACKER_UNIT_ASSERT_SVH
`define GIF_TAG_PACKET_UNPACKER_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define GTPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtpu check failed");

// next-cycle implication, held off during reset
`define GTPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtpu check failed");

`endif

>>> hdl/gtpu_pkg.sv
`timescale 1ns / 1ps

package gtpu_pkg;

  localparam int MAX_REGS = 16;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // result kinds
  localparam logic [2:0] KIND_REGW   = 3'd0;
  localparam logic [2:0] KIND_VERT   = 3'd1;
  localparam logic [2:0] KIND_IMG    = 3'd2;
  localparam logic [2:0] KIND_BADREG = 3'd3;
  localparam logic [2:0] KIND_BADFMT = 3'd4;

  // tag data formats
  localparam logic [1:0] MODE_PACKED  = 2'd0;
  localparam logic [1:0] MODE_REGLIST = 2'd1;

  // packed register codes
  localparam logic [3:0] CODE_PRIM  = 4'h0;
  localparam logic [3:0] CODE_RGBAQ = 4'h1;
  localparam logic [3:0] CODE_XYZ2  = 4'h4;
  localparam logic [3:0] CODE_AD    = 4'hE;

  // register addresses
  localparam logic [6:0] ADDR_PRIM  = 7'h00;
  localparam logic [6:0] ADDR_RGBAQ = 7'h01;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  reg_addr;
    logic [63:0] data;
    logic [15:0] vert_x;
    logic [15:0] vert_y;
    logic [23:0] vert_z;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        tag_held;
    logic [14:0] loop_count;
    logic [14:0] loops_left;
    logic [1:0]  data_mode;
    logic [4:0]  reg_count;
    logic [4:0]  reg_index;
  } tag_state_t;

endpackage

>>> hdl/gtpu_decode.sv
`timescale 1ns / 1ps

// one qword against the held tag state: next state and up to two results
module gtpu_decode (
  input  gtpu_pkg::tag_state_t st,
  input  logic [3:0]           code,
  input  logic [63:0]          qword_lo,
  input  logic [63:0]          qword_hi,
  output gtpu_pkg::tag_state_t st_nxt,
  output logic                 codes_load,
  output logic [1:0]           res_cnt,
  output gtpu_pkg::result_t    res0,
  output gtpu_pkg::result_t    res1
);

  logic [4:0]  tag_cnt_raw;
  logic [4:0]  tag_cnt;
  logic [14:0] tag_loops;
  logic [14:0] loops_dec;
  logic [3:0]  code_eff;
  logic        held;

  assign tag_loops   = qword_lo[14:0];
  assign tag_cnt_raw = (qword_lo[63:60] == 4'd0) ? 5'd16 : {1'b0, qword_lo[63:60]};
  assign tag_cnt     = (tag_cnt_raw > 5'(gtpu_pkg::MAX_REGS)) ?
                       5'(gtpu_pkg::MAX_REGS) : tag_cnt_raw;
  assign loops_dec   = st.loops_left - 15'd1;
  assign code_eff    = (st.reg_index < st.reg_count) ? code : gtpu_pkg::CODE_PRIM;

  always_comb begin
    st_nxt     = st;
    codes_load = 1'b0;
    res_cnt    = 2'd0;
    res0       = '0;
    res1       = '0;
    held       = st.tag_held;

    // packed block done: release the tag and parse this qword as a new one
    if (st.data_mode == gtpu_pkg::MODE_PACKED && st.reg_index == st.reg_count) begin
      held = 1'b0;
    end
    st_nxt.tag_held = held;

    if (!held) begin
      st_nxt.loop_count = tag_loops;
      st_nxt.tag_held   = (tag_loops != 15'd0);
      if (tag_loops != 15'd0) begin
        st_nxt.loops_left = tag_loops;
        st_nxt.data_mode  = qword_lo[59:58];
        st_nxt.reg_count  = tag_cnt;
        st_nxt.reg_index  = 5'd0;
        codes_load        = 1'b1;
        if (qword_lo[46]) begin
          res_cnt       = 2'd1;
          res0.kind     = gtpu_pkg::KIND_REGW;
          res0.reg_addr = gtpu_pkg::ADDR_PRIM;
          res0.data     = {53'd0, qword_lo[57:47]};
        end
      end
    end else if (st.data_mode == gtpu_pkg::MODE_PACKED) begin
      res_cnt = 2'd1;
      case (code_eff)
        gtpu_pkg::CODE_PRIM: begin
          res0.kind     = gtpu_pkg::KIND_REGW;
          res0.reg_addr = gtpu_pkg::ADDR_PRIM;
          res0.data     = {53'd0, qword_lo[10:0]};
        end
        gtpu_pkg::CODE_RGBAQ: begin
          res0.kind     = gtpu_pkg::KIND_REGW;
          res0.reg_addr = gtpu_pkg::ADDR_RGBAQ;
          res0.data     = qword_lo;
        end
        gtpu_pkg::CODE_XYZ2: begin
          res0.kind   = gtpu_pkg::KIND_VERT;
          res0.vert_x = qword_lo[15:0];
          res0.vert_y = qword_lo[47:32];
          res0.vert_z = qword_hi[27:4];
        end
        gtpu_pkg::CODE_AD: begin
          res0.kind     = gtpu_pkg::KIND_REGW;
          res0.reg_addr = qword_hi[6:0];
          res0.data     = qword_lo;
        end
        default: begin
          res0.kind = gtpu_pkg::KIND_BADREG;
          res0.data = {60'd0, code_eff};
        end
      endcase
      // register-major: each code repeats loop_count times
      if (loops_dec == 15'd0) begin
        st_nxt.loops_left = st.loop_count;
        st_nxt.reg_index  = st.reg_index + 5'd1;
      end else begin
        st_nxt.loops_left = loops_dec;
      end
    end else if (st.data_mode == gtpu_pkg::MODE_REGLIST) begin
      res_cnt         = 2'd1;
      res0.kind       = gtpu_pkg::KIND_BADFMT;
      res0.data       = {62'd0, st.data_mode};
      st_nxt.tag_held = 1'b0;
    end else begin
      res_cnt   = 2'd2;
      res0.kind = gtpu_pkg::KIND_IMG;
      res0.data = qword_lo;
      res1.kind = gtpu_pkg::KIND_IMG;
      res1.data = qword_hi;
      if (st.loops_left == 15'd1) begin
        st_nxt.tag_held = 1'b0;
      end
      st_nxt.loops_left = loops_dec;
    end

    if (res_cnt == 2'd1) begin
      res0.last = 1'b1;
    end
    if (res_cnt == 2'd2) begin
      res1.last = 1'b1;
    end
  end

endmodule

>>> hdl/gif_tag_packet_unpacker_unit.sv
`timescale 1ns / 1ps

// channel   dir  handshake             payload
// in_       in   in_valid / in_ready   in_qword_lo, in_qword_hi
// out_      out  out_valid / out_ready out_kind, out_reg_addr, out_data,
//                                      out_vert_x, out_vert_y, out_vert_z, out_last
//
// a request is decoded in the cycle it is accepted; its results land in a
// four-entry result queue and leave one per cycle while out_ready is high
// tag, packed and bad-format requests give at most one result, so they are
// taken one per cycle while out_ready is high; image requests give two
// results; their rate is set by the single result port draining the queue
// in_ready is high while the queue has room for two results, so it never
// depends on out_ready in the same cycle
// rst_n (synchronous) empties the queue and drops any held tag

module gif_tag_packet_unpacker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_qword_lo,
  input  logic [63:0] in_qword_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [6:0]  out_reg_addr,
  output logic [63:0] out_data,
  output logic [15:0] out_vert_x,
  output logic [15:0] out_vert_y,
  output logic [23:0] out_vert_z,
  output logic        out_last
);

  // held tag state
  gtpu_pkg::tag_state_t st_r;
  gtpu_pkg::tag_state_t st_nxt;
  logic [3:0]           reg_codes_r [gtpu_pkg::MAX_REGS];
  logic [3:0]           code_cur;

  // decoder outputs
  logic                 codes_load;
  logic [1:0]           res_cnt;
  gtpu_pkg::result_t    res0;
  gtpu_pkg::result_t    res1;

  // result queue
  gtpu_pkg::result_t            q_r [gtpu_pkg::Q_DEPTH];
  logic [gtpu_pkg::Q_PTR_W-1:0] head_r;
  logic [gtpu_pkg::Q_PTR_W-1:0] head_nxt;
  logic [gtpu_pkg::Q_PTR_W-1:0] tail_r;
  logic [gtpu_pkg::Q_PTR_W-1:0] tail_nxt;
  logic [gtpu_pkg::Q_CNT_W-1:0] cnt_r;
  logic [gtpu_pkg::Q_CNT_W-1:0] cnt_nxt;
  logic [gtpu_pkg::Q_CNT_W-1:0] push_cnt;
  logic                         in_acc;
  logic                         out_acc;
  gtpu_pkg::result_t            head_res;

  // current register code, only meaningful while reg_index < reg_count
  assign code_cur = reg_codes_r[st_r.reg_index[3:0]];

  gtpu_decode u_decode (
    .st         (st_r),
    .code       (code_cur),
    .qword_lo   (in_qword_lo),
    .qword_hi   (in_qword_hi),
    .st_nxt     (st_nxt),
    .codes_load (codes_load),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  // room for a two-result request
  assign in_ready = (cnt_r <= gtpu_pkg::Q_CNT_W'(gtpu_pkg::Q_DEPTH - 2));
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign push_cnt = in_acc ? {1'b0, res_cnt} : '0;

  assign head_nxt = out_acc ? head_r + 1'b1 : head_r;
  assign tail_nxt = tail_r + push_cnt[gtpu_pkg::Q_PTR_W-1:0];
  assign cnt_nxt  = cnt_r + push_cnt - {{(gtpu_pkg::Q_CNT_W-1){1'b0}}, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // register codes: written only by a tag, for indices below its count
  always_ff @(posedge clk) begin
    for (int i = 0; i < gtpu_pkg::MAX_REGS; i++) begin
      if (in_acc && codes_load && (5'(i) < st_nxt.reg_count)) begin
        reg_codes_r[i] <= in_qword_hi[4*i +: 4];
      end
    end
  end

  // queue payload, first result at tail, second right behind it
  always_ff @(posedge clk) begin
    if (in_acc && res_cnt != 2'd0) begin
      q_r[tail_r] <= res0;
    end
    if (in_acc && res_cnt == 2'd2) begin
      q_r[tail_r + 1'b1] <= res1;
    end
  end

  assign head_res     = q_r[head_r];
  assign out_valid    = (cnt_r != '0);
  assign out_kind     = head_res.kind;
  assign out_reg_addr = head_res.reg_addr;
  assign out_data     = head_res.data;
  assign out_vert_x   = head_res.vert_x;
  assign out_vert_y   = head_res.vert_y;
  assign out_vert_z   = head_res.vert_z;
  assign out_last     = head_res.last;

endmodule

>>> hdl/gtpu_checker.sv
`timescale 1ns / 1ps

`include "gif_tag_packet_unpacker_unit_assert.svh"

module gtpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [6:0]  out_reg_addr,
  input logic [63:0] out_data,
  input logic [15:0] out_vert_x,
  input logic [15:0] out_vert_y,
  input logic [23:0] out_vert_z,
  input logic        out_last
);

  // a stalled result holds
  `GTPU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data) && $stable(out_kind) && $stable(out_last))

  // first image word is always followed by the closing image word
  `GTPU_ASSERT_NEXT(a_img_pair, clk, rst_n, out_valid && out_ready && out_kind == gtpu_pkg::KIND_IMG && !out_last, out_valid && out_kind == gtpu_pkg::KIND_IMG && out_last)

  // vertex fields only carry data on a vertex push
  `GTPU_ASSERT_NOW(a_vert_zero, clk, rst_n, out_valid && out_kind != gtpu_pkg::KIND_VERT, out_vert_x == 16'd0 && out_vert_y == 16'd0 && out_vert_z == 24'd0)

  // only a register write names a register
  `GTPU_ASSERT_NOW(a_addr_zero, clk, rst_n, out_valid && out_kind != gtpu_pkg::KIND_REGW, out_reg_addr == 7'd0)

  // error kinds carry at most a 4-bit code and are always last
  `GTPU_ASSERT_NOW(a_err_data, clk, rst_n, out_valid && (out_kind == gtpu_pkg::KIND_BADREG || out_kind == gtpu_pkg::KIND_BADFMT), out_data[63:4] == 60'd0 && out_last)

endmodule

bind gif_tag_packet_unpacker_unit gtpu_checker u_checker (.*);
